/* rtl/assert_macros.svh */
// Assertion helpers shared by the scheduler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define MLFQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MLFQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mlfq_pkg.sv */
// ----------------------------------------------------------------------------
// Scheduler package
// Payload types, command and status groups and codes of the scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_JOBS_IN_USE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM2 = 3'd4;

   localparam logic [4:0] RST_JOBS_IN_USE = 5'd0;
   localparam logic [15:0] RST_BOOST_PERIOD = 16'd50;
   localparam logic [7:0] RST_QUANTUM0 = 8'd8;
   localparam logic [7:0] RST_QUANTUM1 = 8'd24;
   localparam logic [7:0] RST_QUANTUM2 = 8'd48;

   localparam logic [7:0] USAGE_MAX = 8'd255;

   typedef struct packed {
      logic        action;
      logic [3:0]  slot;
      logic [31:0] arrival;
      logic [15:0] burst;
   } req_item_type;

   typedef struct packed {
      logic [31:0] tick_time;
      logic        idle;
      logic [3:0]  running_slot;
      logic        first_start;
      logic        finished;
      logic        all_done;
   } rsp_item_type;

   typedef struct packed {
      logic load;
      logic tick;
      logic boost;
      logic scan;
      logic pick;
      logic exec;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic run_active;
   } dp_status_type;

endpackage

/* rtl/mlfq_ctrl.sv */
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences a tick through boost, scan, pick, execute and report steps (only execute and report mid-quantum).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlfq_ctrl
   import mlfq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          action,
   input  dp_status_type status,
   output logic          busy,
   output dp_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_BOOST = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_PICK  = 6'b001000,
      ST_EXEC  = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic accept;

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && action == ACT_TICK) begin
               state_in = status.run_active ? ST_EXEC : ST_BOOST;
            end
         end
         ST_BOOST: state_in = ST_SCAN;
         ST_SCAN:  state_in = ST_PICK;
         ST_PICK:  state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_EMIT;
         ST_EMIT:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd = '0;
      cmd.load = accept && action == ACT_LOAD;
      cmd.tick = accept && action == ACT_TICK;
      cmd.boost = (state_ff == ST_BOOST);
      cmd.scan = (state_ff == ST_SCAN);
      cmd.pick = (state_ff == ST_PICK);
      cmd.exec = (state_ff == ST_EXEC);
      cmd.emit = (state_ff == ST_EMIT);
   end

   `MLFQ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy, "controller not idle after reset")
   `MLFQ_ASSERT(a_exec_then_emit, clock, reset, cmd.exec |=> cmd.emit, "execute not followed by report")
   `MLFQ_ASSERT(a_tick_busy, clock, reset, cmd.tick |=> busy, "tick transfer did not start work")

endmodule

/* rtl/mlfq_dp.sv */
// ----------------------------------------------------------------------------
// Scheduler datapath
// Job slot table, configuration registers, boost, selection and tick update.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlfq_dp
   import mlfq_pkg::*;
#(
   parameter int MAX_JOBS = 16,
   parameter int LEVELS = 4
)(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  req_item_type          req_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output dp_status_type         status,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item
);

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int LVL_W = $clog2(LEVELS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(LEVELS - 1);

   logic [4:0]  jobs_ff;
   logic [15:0] boost_period_ff;
   logic [7:0]  quantum0_ff, quantum1_ff, quantum2_ff;

   logic [LVL_W-1:0] level_ff [MAX_JOBS];
   logic [LVL_W-1:0] level_in [MAX_JOBS];
   logic [7:0]       usage_ff [MAX_JOBS];
   logic [7:0]       usage_in [MAX_JOBS];
   logic [15:0]      rem_ff [MAX_JOBS];
   logic [15:0]      rem_in [MAX_JOBS];
   logic [31:0]      arrival_ff [MAX_JOBS];
   logic [MAX_JOBS-1:0] started_ff, started_in;
   logic [MAX_JOBS-1:0] elig_ff;
   logic [MAX_JOBS-1:0] in_use;

   logic [31:0]      now_ff, now_in;
   logic [31:0]      last_boost_ff, last_boost_in;
   logic [IDX_W-1:0] active_ff, active_in;
   logic [15:0]      run_left_ff, run_left_in;
   logic             idle_ff, idle_in;
   logic             first_ff, first_in;
   logic             fin_ff, fin_in;
   logic [CNT_W-1:0] completed_count_ff, completed_count_in;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_item_ff;

   logic             boost_due;
   logic             ld_in_range;
   logic [IDX_W-1:0] ld_idx;
   logic             pick_found;
   logic [IDX_W-1:0] pick_idx;
   logic [15:0]      pick_rem, pick_q;
   logic [LVL_W-1:0] pick_lvl;
   logic [15:0]      ex_rem_dec, ex_run_dec;
   logic [7:0]       ex_usage_inc;
   logic [LVL_W-1:0] ex_lvl;
   logic             ex_demote;
   logic [CNT_W-1:0] slots_used;

   function automatic logic [15:0] level_quantum(input logic [LVL_W-1:0] lv,
                                                 input logic [7:0] q0,
                                                 input logic [7:0] q1,
                                                 input logic [7:0] q2);
      logic [7:0] q;
      if (lv == LVL_W'(0)) begin
         q = q0;
      end else if (lv == LVL_W'(1)) begin
         q = q1;
      end else begin
         q = q2;
      end
      if (q == 8'd0) begin
         q = 8'd1;
      end
      return {8'd0, q};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         jobs_ff <= RST_JOBS_IN_USE;
         boost_period_ff <= RST_BOOST_PERIOD;
         quantum0_ff <= RST_QUANTUM0;
         quantum1_ff <= RST_QUANTUM1;
         quantum2_ff <= RST_QUANTUM2;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_JOBS_IN_USE:  jobs_ff <= csr_wdata[4:0];
            CSR_BOOST_PERIOD: boost_period_ff <= csr_wdata;
            CSR_QUANTUM0:     quantum0_ff <= csr_wdata[7:0];
            CSR_QUANTUM1:     quantum1_ff <= csr_wdata[7:0];
            CSR_QUANTUM2:     quantum2_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_JOBS; i++) begin
         in_use[i] = (32'(i) < 32'(jobs_ff));
      end
      slots_used = (32'(jobs_ff) > 32'(MAX_JOBS)) ? CNT_W'(MAX_JOBS) : CNT_W'(jobs_ff);
   end

   assign boost_due = !((now_ff - last_boost_ff) < {16'd0, boost_period_ff});
   assign ld_in_range = (32'(req_item.slot) < 32'(MAX_JOBS));
   assign ld_idx = IDX_W'(req_item.slot);

   always_comb begin
      pick_found = 1'b0;
      pick_idx = '0;
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
         for (int i = MAX_JOBS - 1; i >= 0; i--) begin
            if (elig_ff[i] && level_ff[i] == LVL_W'(lv)) begin
               pick_found = 1'b1;
               pick_idx = IDX_W'(i);
            end
         end
      end
      pick_rem = rem_ff[pick_idx];
      pick_lvl = level_ff[pick_idx];
      pick_q = (pick_lvl >= LAST_LEVEL) ? pick_rem :
               level_quantum(pick_lvl, quantum0_ff, quantum1_ff, quantum2_ff);
   end

   always_comb begin
      ex_rem_dec = rem_ff[active_ff] - 16'd1;
      ex_usage_inc = (usage_ff[active_ff] < USAGE_MAX) ? usage_ff[active_ff] + 8'd1
                                                       : usage_ff[active_ff];
      ex_run_dec = run_left_ff - 16'd1;
      ex_lvl = level_ff[active_ff];
      ex_demote = (ex_rem_dec != 16'd0) && (ex_run_dec == 16'd0) && (ex_lvl < LAST_LEVEL) &&
                  ({8'd0, ex_usage_inc} >=
                   level_quantum(ex_lvl, quantum0_ff, quantum1_ff, quantum2_ff));
   end

   always_comb begin
      level_in = level_ff;
      usage_in = usage_ff;
      rem_in = rem_ff;
      started_in = started_ff;
      now_in = now_ff;
      last_boost_in = last_boost_ff;
      active_in = active_ff;
      run_left_in = run_left_ff;
      idle_in = idle_ff;
      first_in = first_ff;
      fin_in = fin_ff;
      completed_count_in = completed_count_ff;

      if (cmd.load && ld_in_range) begin
         rem_in[ld_idx] = req_item.burst;
         level_in[ld_idx] = '0;
         usage_in[ld_idx] = '0;
         started_in[ld_idx] = 1'b0;
         if (run_left_ff != 16'd0 && active_ff == ld_idx) begin
            run_left_in = '0;
         end
      end

      if (cmd.tick) begin
         idle_in = 1'b0;
      end

      if (cmd.boost && boost_due) begin
         for (int i = 0; i < MAX_JOBS; i++) begin
            if (in_use[i] && rem_ff[i] != 16'd0) begin
               level_in[i] = '0;
               usage_in[i] = '0;
            end
         end
         last_boost_in = now_ff;
      end

      if (cmd.pick) begin
         idle_in = !pick_found;
         if (pick_found) begin
            active_in = pick_idx;
            run_left_in = (pick_rem < pick_q) ? pick_rem : pick_q;
         end
      end

      if (cmd.exec) begin
         now_in = now_ff + 32'd1;
         first_in = 1'b0;
         fin_in = 1'b0;
         if (!idle_ff) begin
            first_in = !started_ff[active_ff];
            started_in[active_ff] = 1'b1;
            rem_in[active_ff] = ex_rem_dec;
            usage_in[active_ff] = ex_usage_inc;
            run_left_in = ex_run_dec;
            if (ex_rem_dec == 16'd0) begin
               fin_in = 1'b1;
               run_left_in = '0;
            end else if (ex_demote) begin
               level_in[active_ff] = ex_lvl + LVL_W'(1);
               usage_in[active_ff] = '0;
            end
         end
      end

      if (cmd.emit) begin
         completed_count_in = '0;
         for (int i = 0; i < MAX_JOBS; i++) begin
            if (in_use[i] && rem_ff[i] == 16'd0) begin
               completed_count_in = completed_count_in + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_JOBS; i++) begin
            level_ff[i] <= '0;
            usage_ff[i] <= '0;
            rem_ff[i] <= '0;
         end
         started_ff <= '0;
         now_ff <= '0;
         last_boost_ff <= '0;
         active_ff <= '0;
         run_left_ff <= '0;
         idle_ff <= 1'b0;
         first_ff <= 1'b0;
         fin_ff <= 1'b0;
         completed_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff <= level_in;
         usage_ff <= usage_in;
         rem_ff <= rem_in;
         started_ff <= started_in;
         now_ff <= now_in;
         last_boost_ff <= last_boost_in;
         active_ff <= active_in;
         run_left_ff <= run_left_in;
         idle_ff <= idle_in;
         first_ff <= first_in;
         fin_ff <= fin_in;
         completed_count_ff <= completed_count_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && ld_in_range) begin
         arrival_ff[ld_idx] <= req_item.arrival;
      end
      if (cmd.scan) begin
         for (int i = 0; i < MAX_JOBS; i++) begin
            elig_ff[i] <= in_use[i] && rem_ff[i] != 16'd0 && arrival_ff[i] <= now_ff;
         end
      end
      if (cmd.emit) begin
         rsp_item_ff.tick_time <= now_ff - 32'd1;
         rsp_item_ff.idle <= idle_ff;
         rsp_item_ff.running_slot <= idle_ff ? 4'd0 : 4'(active_ff);
         rsp_item_ff.first_start <= first_ff;
         rsp_item_ff.finished <= fin_ff;
         rsp_item_ff.all_done <= (completed_count_in >= slots_used);
      end
   end

   assign status.run_active = (run_left_ff != 16'd0);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   `MLFQ_ASSERT(a_rsp_pulse, clock, reset, rsp_valid_ff |=> !rsp_valid_ff,
                "result strobe longer than one cycle")
   `MLFQ_ASSERT(a_run_within_rem, clock, reset,
                (run_left_ff != 16'd0) |-> (run_left_ff <= rem_ff[active_ff]),
                "quantum exceeds remaining work")
   `MLFQ_ASSERT(a_emit_after_exec, clock, reset, cmd.emit |-> $past(cmd.exec),
                "report without execute step")

endmodule

/* rtl/mlfq_tick_scheduler.sv */
// ----------------------------------------------------------------------------
// Multilevel feedback queue tick scheduler
// Four-level feedback queue scheduler over a table of job slots.
// ----------------------------------------------------------------------------
// A load transfer is taken in the cycle start is seen and busy stays low, so
// loads may follow each other every cycle and produce no result. A tick
// transfer keeps busy high while it works: when a quantum is in progress the
// controller goes straight to its execute and report steps; otherwise the
// block walks through its boost, eligibility scan and priority pick steps in
// the controller's sequence first. The result strobe is registered from the
// report step. Each result is on rsp_item for exactly one cycle with rsp_valid
// high, and the receiver cannot stall it. Configuration writes take effect at
// the clock edge where csr_we is high and must only be made while busy is low.

module mlfq_tick_scheduler
   import mlfq_pkg::*;
#(
   parameter int MAX_JOBS = 16,
   parameter int LEVELS = 4
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   mlfq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_item.action),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   mlfq_dp #(
      .MAX_JOBS (MAX_JOBS),
      .LEVELS   (LEVELS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

/* verif/mlfq_tick_scheduler_tb.sv */
// ----------------------------------------------------------------------------
// Scheduler testbench
// Drives load and tick commands into the feedback queue scheduler, predicts
// every tick report from a behavioral copy of the scheduler and compares each
// report as a whole. Registers are rewritten between test phases.
// ----------------------------------------------------------------------------
module mlfq_tick_scheduler_tb;
   import mlfq_pkg::*;

   localparam int NSLOT = 16;
   localparam int NLVL = 4;
   localparam int DRAIN_CYCLES = 12;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_item_type req_item = '0;
   logic rsp_valid;
   rsp_item_type rsp_item;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mlfq_tick_scheduler dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted scheduler state.
   logic [4:0] m_jobs;
   logic [15:0] m_period;
   logic [7:0] m_quant[3];
   logic [1:0] m_level[NSLOT];
   logic [7:0] m_usage[NSLOT];
   logic [15:0] m_remain[NSLOT];
   logic [31:0] m_arrive[NSLOT];
   logic m_started[NSLOT];
   logic [31:0] m_now, m_last_boost;
   logic [3:0] m_active;
   logic [15:0] m_run_left;

   rsp_item_type expected_reports[$];
   int mismatches = 0;
   bit no_idle = 1'b0;
   longint cycles = 0;

   function automatic int used_slots();
      return (m_jobs > NSLOT) ? NSLOT : m_jobs;
   endfunction

   function automatic int quantum_of(int lvl);
      int q;
      q = m_quant[(lvl > 2) ? 2 : lvl];
      return (q == 0) ? 1 : q;
   endfunction

   function automatic bit all_finished();
      int c;
      c = 0;
      for (int i = 0; i < used_slots(); i++)
         if (m_remain[i] == 0) c++;
      return c >= used_slots();
   endfunction

   task automatic predict_command(req_item_type it);
      rsp_item_type r;
      int pick, q, rem, lvl;
      if (it.action == ACT_LOAD) begin
         m_arrive[it.slot] = it.arrival;
         m_remain[it.slot] = it.burst;
         m_level[it.slot] = 2'd0;
         m_usage[it.slot] = 8'd0;
         m_started[it.slot] = 1'b0;
         if (m_run_left != 0 && m_active == it.slot) m_run_left = 16'd0;
         return;
      end
      r = '0;
      r.tick_time = m_now;
      if (m_run_left == 0) begin
         if (32'(m_now - m_last_boost) >= {16'd0, m_period}) begin
            for (int i = 0; i < used_slots(); i++)
               if (m_remain[i] != 0) begin
                  m_level[i] = 2'd0;
                  m_usage[i] = 8'd0;
               end
            m_last_boost = m_now;
         end
         pick = -1;
         for (int l = 0; l < NLVL && pick < 0; l++)
            for (int i = 0; i < used_slots() && pick < 0; i++)
               if (m_level[i] == l && m_arrive[i] <= m_now && m_remain[i] != 0) pick = i;
         if (pick < 0) begin
            m_now++;
            r.idle = 1'b1;
            r.all_done = all_finished();
            expected_reports.push_back(r);
            return;
         end
         m_active = 4'(pick);
         rem = m_remain[pick];
         lvl = m_level[pick];
         q = (lvl >= NLVL - 1) ? rem : quantum_of(lvl);
         m_run_left = 16'((rem < q) ? rem : q);
      end
      r.running_slot = m_active;
      if (!m_started[m_active]) begin
         m_started[m_active] = 1'b1;
         r.first_start = 1'b1;
      end
      m_remain[m_active]--;
      if (m_usage[m_active] < USAGE_MAX) m_usage[m_active]++;
      m_run_left--;
      m_now++;
      if (m_remain[m_active] == 0) begin
         r.finished = 1'b1;
         m_run_left = 16'd0;
      end else if (m_run_left == 0) begin
         lvl = m_level[m_active];
         if (lvl < NLVL - 1 && m_usage[m_active] >= quantum_of(lvl)) begin
            m_level[m_active] = 2'(lvl + 1);
            m_usage[m_active] = 8'd0;
         end
      end
      r.all_done = all_finished();
      expected_reports.push_back(r);
   endtask

   task automatic idle_gap();
      if (!no_idle && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 12)) @(negedge clock);
   endtask

   task automatic send_command(req_item_type it);
      idle_gap();
      @(negedge clock);
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      predict_command(it);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic load_job(int s, logic [31:0] arr, logic [15:0] bur);
      req_item_type it;
      it = '0;
      it.action = ACT_LOAD;
      it.slot = 4'(s);
      it.arrival = arr;
      it.burst = bur;
      send_command(it);
   endtask

   task automatic run_ticks(int n);
      req_item_type it;
      for (int i = 0; i < n; i++) begin
         it = req_item_type'({$urandom, $urandom});
         it.action = ACT_TICK;
         send_command(it);
      end
   endtask

   task automatic wait_quiet();
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_JOBS_IN_USE: m_jobs = val[4:0];
         CSR_BOOST_PERIOD: m_period = val;
         CSR_QUANTUM0: m_quant[0] = val[7:0];
         CSR_QUANTUM1: m_quant[1] = val[7:0];
         CSR_QUANTUM2: m_quant[2] = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(int jobs, int period, int q0, int q1, int q2);
      wait_quiet();
      write_reg(CSR_JOBS_IN_USE, 16'(jobs));
      write_reg(CSR_BOOST_PERIOD, 16'(period));
      write_reg(CSR_QUANTUM0, 16'(q0));
      write_reg(CSR_QUANTUM1, 16'(q1));
      write_reg(CSR_QUANTUM2, 16'(q2));
   endtask

   task automatic test_directed();
      run_ticks(2);
      set_regs(3, 20, 1, 2, 3);
      load_job(0, 32'd0, 16'd1);
      load_job(1, 32'd0, 16'hFFFF);
      load_job(2, 32'hFFFF_FFFF, 16'd3);
      load_job(15, 32'd0, 16'd0);
      run_ticks(6);
      load_job(1, 32'd1, 16'd4);
      run_ticks(5);
      set_regs(31, 0, 0, 0, 0);
      run_ticks(4);
      set_regs(0, 16'hFFFF, 255, 255, 255);
      run_ticks(2);
   endtask

   task automatic test_random_mix(int n);
      req_item_type it;
      for (int i = 0; i < n; i++) begin
         it = req_item_type'({$urandom, $urandom});
         if ($urandom_range(0, 3) == 0) begin
            it.action = ACT_LOAD;
            if ($urandom_range(0, 3) != 0) it.arrival = m_now + $urandom_range(0, 30);
            if ($urandom_range(0, 3) != 0) it.burst = 16'($urandom_range(0, 40));
         end else
            it.action = ACT_TICK;
         send_command(it);
      end
   endtask

   task automatic test_random_phases();
      set_regs(16, 40, 3, 6, 10);
      for (int s = 0; s < NSLOT; s++)
         load_job(s, 32'($urandom_range(0, 20)), 16'($urandom_range(1, 30)));
      test_random_mix(200);
      set_regs(6, 7, 1, 1, 2);
      test_random_mix(150);
      set_regs(20, 65535, 8, 24, 48);
      test_random_mix(150);
      no_idle = 1'b1;
      set_regs(10, 1, 2, 4, 255);
      test_random_mix(100);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected report %p", rsp_item);
         end else if (rsp_item !== expected_reports[0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("report mismatch: expected %p actual %p",
                        expected_reports[0], rsp_item);
            void'(expected_reports.pop_front());
         end else
            void'(expected_reports.pop_front());
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("mlfq_tick_scheduler verification failed");
         $finish;
      end
   end

   initial begin
      m_jobs = RST_JOBS_IN_USE;
      m_period = RST_BOOST_PERIOD;
      m_quant[0] = RST_QUANTUM0;
      m_quant[1] = RST_QUANTUM1;
      m_quant[2] = RST_QUANTUM2;
      for (int i = 0; i < NSLOT; i++) begin
         m_level[i] = 2'd0;
         m_usage[i] = 8'd0;
         m_remain[i] = 16'd0;
         m_arrive[i] = 32'd0;
         m_started[i] = 1'b0;
      end
      m_now = 32'd0;
      m_last_boost = 32'd0;
      m_active = 4'd0;
      m_run_left = 16'd0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phases();
      wait_quiet();
      if (mismatches == 0 && expected_reports.size() == 0)
         $display("mlfq_tick_scheduler verification clean");
      else
         $display("mlfq_tick_scheduler verification failed");
      $finish;
   end
endmodule

/* files.f */
+incdir+rtl
rtl/mlfq_pkg.sv
rtl/mlfq_ctrl.sv
rtl/mlfq_dp.sv
rtl/mlfq_tick_scheduler.sv
verif/mlfq_tick_scheduler_tb.sv
